// File: hw/rtl/fsa_pkg.sv
// ============================================================================
// fsa_pkg
// Shared types and constants of the flow slot allocator: op codes, command
// kinds, slot entry layout, status codes and the back-end state encoding.
// ============================================================================
package fsa_pkg;

    // Input op codes
    localparam logic [2:0] OP_PUT      = 3'd0;
    localparam logic [2:0] OP_CLEAR    = 3'd1;
    localparam logic [2:0] OP_READ     = 3'd2;
    localparam logic [2:0] OP_SET_SEQ  = 3'd3;
    localparam logic [2:0] OP_SET_LINK = 3'd4;
    localparam logic [2:0] OP_AT_INDEX = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Classified command kinds
    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_CLEAR,
        CMD_READ,
        CMD_SET_SEQ,
        CMD_SET_LINK,
        CMD_AT_INDEX,
        CMD_NOP
    } cmd_kind_t;

    // One command passed from front to back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [31:0]        flow_id;
        logic [9:0]         slot_index;
        logic signed [63:0] write_value;
    } cmd_t;

    // One slot of the flow table
    typedef struct packed {
        logic [31:0]        id;
        logic signed [63:0] seq;
        logic [31:0]        link;
    } entry_t;

    localparam entry_t ENTRY_EMPTY = '{id: 32'd0, seq: {64{1'b1}}, link: 32'd0};
    localparam entry_t ENTRY_ZERO  = '{id: 32'd0, seq: 64'd0, link: 32'd0};

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_EXEC
    } back_state_t;

endpackage

// File: hw/rtl/fsa_front.sv
// ============================================================================
// fsa_front
// Input side: holds the capacity register, derives the slot mask, accepts
// input beats, classifies the op and pushes a command into the queue.
// ============================================================================
module fsa_front #(
    parameter int ADDR_W = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [10:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          op,
    input  logic [31:0]         flow_id,
    input  logic [9:0]          slot_index,
    input  logic signed [63:0]  write_value,
    input  logic                q_full,
    input  logic                clearing,
    output logic                push,
    output fsa_pkg::cmd_t       cmd,
    output logic [ADDR_W-1:0]   mask,
    output logic                cfg_clear
);
    import fsa_pkg::*;

    localparam logic [10:0] REQ_RESET = 11'd1024;

    logic [ADDR_W-1:0] mask_reg;
    logic [ADDR_W-1:0] mask_next;
    cmd_kind_t         kind;

    // Round the request up to a power of two and return size minus one
    function automatic logic [10:0] req_mask(input logic [10:0] req);
        logic [10:0] m;
        m = (req == 11'd0) ? 11'd0 : req - 11'd1;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        return m;
    endfunction

    // Cap the mask at the table depth by width
    assign mask_next = ADDR_W'(req_mask(cfg_wdata));

    // Hold the mask of the current table size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= ADDR_W'(req_mask(REQ_RESET));
        end
        else if (cfg_we)
        begin
            mask_reg <= mask_next;
        end
    end

    assign mask      = mask_reg;
    assign cfg_clear = cfg_we;

    // Classify the op
    always_comb
    begin
        unique case (op)
            OP_PUT:      kind = CMD_PUT;
            OP_CLEAR:    kind = CMD_CLEAR;
            OP_READ:     kind = CMD_READ;
            OP_SET_SEQ:  kind = CMD_SET_SEQ;
            OP_SET_LINK: kind = CMD_SET_LINK;
            OP_AT_INDEX: kind = CMD_AT_INDEX;
            default:     kind = CMD_NOP;
        endcase
    end

    // Accept a beat whenever the queue has room and no clearing pass runs
    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready;

    assign cmd.kind        = kind;
    assign cmd.flow_id     = flow_id;
    assign cmd.slot_index  = slot_index;
    assign cmd.write_value = write_value;

endmodule

// File: hw/rtl/fsa_queue.sv
// ============================================================================
// fsa_queue
// Short command queue between front and back, so each side stalls on its own.
// ============================================================================
module fsa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fsa_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output fsa_pkg::cmd_t  head,
    output logic           empty
);
    import fsa_pkg::*;

    localparam logic [QPTR_W:0] COUNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    cmd_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full  = (count_reg == COUNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/fsa_back.sv
// ============================================================================
// fsa_back
// Execution side: slot memory, id counter, occupancy, probe sequencer,
// clearing pass and the result register.
// ============================================================================
module fsa_back #(
    parameter int ADDR_W = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_clear,
    input  logic [ADDR_W-1:0]   mask,
    input  fsa_pkg::cmd_t       head,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         new_id,
    output logic [31:0]         slot_flow_id,
    output logic signed [63:0]  slot_sequence,
    output logic [31:0]         slot_linked,
    output logic [10:0]         occupied_count,
    output logic [1:0]          status
);
    import fsa_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    typedef struct packed {
        logic [31:0] new_id;
        entry_t      ent;
        logic [10:0] occ;
        logic [1:0]  status;
    } result_t;

    // Slot memory
    entry_t            mem [DEPTH];
    entry_t            rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [31:0]       counter_reg;
    logic [31:0]       counter_next;
    logic [ADDR_W:0]   occ_reg;
    logic [ADDR_W:0]   occ_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic [ADDR_W-1:0] slot_reg;
    logic [ADDR_W-1:0] slot_next;
    logic [ADDR_W-1:0] probe_reg;
    logic [ADDR_W-1:0] probe_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           res_reg;
    result_t           res_next;
    logic              load;

    logic [31:0]       cand_next;
    logic [ADDR_W-1:0] head_slot;
    logic              pop_ok;
    logic              hit;
    logic              probe_last;
    entry_t            put_entry;

    // Step the id counter, skipping zero on wrap
    function automatic logic [31:0] bump(input logic [31:0] c);
        logic [31:0] n;
        n = c + 32'd1;
        return (n == 32'd0) ? 32'd1 : n;
    endfunction

    assign cand_next  = bump(counter_reg);
    assign head_slot  = (head.kind == CMD_AT_INDEX) ?
                        (ADDR_W'(head.slot_index) & mask) :
                        (head.flow_id[ADDR_W-1:0] & mask);
    assign pop_ok     = !q_empty && (!out_valid_reg || out_ready) && !cfg_clear;
    assign hit        = (rd_data_reg.id == 32'd0);
    assign probe_last = (probe_reg == mask);
    assign put_entry  = '{id: counter_reg, seq: {64{1'b1}}, link: 32'd0};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_ok)
                begin
                    state_next = (head.kind == CMD_PUT) ? ST_PROBE : ST_EXEC;
                end
            end
            ST_PROBE:
            begin
                if (hit || probe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_clear)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Datapath and outputs of each state
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = slot_reg;
        mem_wdata     = ENTRY_EMPTY;
        mem_raddr     = cand_next[ADDR_W-1:0] & mask;
        q_pop         = 1'b0;
        load          = 1'b0;
        counter_next  = counter_reg;
        occ_next      = occ_reg;
        clr_addr_next = clr_addr_reg;
        slot_next     = slot_reg;
        probe_next    = probe_reg;
        cmd_next      = cmd_reg;
        res_next      = res_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                counter_next  = 32'd0;
                occ_next      = '0;
            end
            ST_IDLE:
            begin
                // Pop a command and issue its first slot read
                if (pop_ok)
                begin
                    q_pop    = 1'b1;
                    cmd_next = head;
                    if (head.kind == CMD_PUT)
                    begin
                        counter_next = cand_next;
                        probe_next   = '0;
                        slot_next    = cand_next[ADDR_W-1:0] & mask;
                    end
                    else
                    begin
                        slot_next = head_slot;
                        mem_raddr = head_slot;
                    end
                end
            end
            ST_PROBE:
            begin
                // Check one slot a cycle while the next one is read
                counter_next = cand_next;
                slot_next    = cand_next[ADDR_W-1:0] & mask;
                probe_next   = probe_reg + 1'b1;
                if (hit)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = put_entry;
                    occ_next        = occ_reg + 1'b1;
                    load            = 1'b1;
                    res_next.new_id = counter_reg;
                    res_next.ent    = put_entry;
                    res_next.occ    = 11'(occ_reg + 1'b1);
                    res_next.status = STATUS_OK;
                end
                else if (probe_last)
                begin
                    load            = 1'b1;
                    res_next.new_id = 32'd0;
                    res_next.ent    = ENTRY_ZERO;
                    res_next.occ    = 11'(occ_reg);
                    res_next.status = STATUS_FULL;
                end
            end
            ST_EXEC:
            begin
                load            = 1'b1;
                res_next.new_id = 32'd0;
                res_next.ent    = rd_data_reg;
                res_next.status = STATUS_OK;
                case (cmd_reg.kind)
                    CMD_CLEAR:
                    begin
                        if (cmd_reg.flow_id != 32'd0 && rd_data_reg.id == cmd_reg.flow_id)
                        begin
                            mem_we       = 1'b1;
                            mem_wdata    = ENTRY_EMPTY;
                            res_next.ent = ENTRY_EMPTY;
                            if (occ_reg != '0)
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            res_next.status = STATUS_MISMATCH;
                        end
                    end
                    CMD_SET_SEQ:
                    begin
                        mem_we           = 1'b1;
                        mem_wdata        = rd_data_reg;
                        mem_wdata.seq    = cmd_reg.write_value;
                        res_next.ent     = mem_wdata;
                    end
                    CMD_SET_LINK:
                    begin
                        mem_we           = 1'b1;
                        mem_wdata        = rd_data_reg;
                        mem_wdata.link   = cmd_reg.write_value[31:0];
                        res_next.ent     = mem_wdata;
                    end
                    CMD_NOP:
                    begin
                        res_next.ent = ENTRY_ZERO;
                    end
                    default:
                    begin
                        res_next.ent = rd_data_reg;
                    end
                endcase
                res_next.occ = 11'(occ_next);
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        // Drop the table on a configuration write
        if (cfg_clear)
        begin
            clr_addr_next = '0;
            counter_next  = 32'd0;
            occ_next      = '0;
        end
    end

    assign out_valid_next = load || (out_valid_reg && !out_ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            counter_reg   <= 32'd0;
            occ_reg       <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            occ_reg       <= occ_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        probe_reg <= probe_next;
        cmd_reg   <= cmd_next;
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign clearing       = (state_reg == ST_CLEAR);
    assign out_valid      = out_valid_reg;
    assign new_id         = res_reg.new_id;
    assign slot_flow_id   = res_reg.ent.id;
    assign slot_sequence  = res_reg.ent.seq;
    assign slot_linked    = res_reg.ent.link;
    assign occupied_count = res_reg.occ;
    assign status         = res_reg.status;

endmodule

// File: hw/rtl/flow_slot_allocator_top.sv
// ============================================================================
// flow_slot_allocator_top
// Flow table of power-of-two slots with id allocation by linear probing.
//
//   Channel   Signals                                  Moves
//   input     in_valid / in_ready                      op, flow_id, slot_index,
//                                                      write_value
//   output    out_valid / out_ready                    new_id, slot_flow_id,
//                                                      slot_sequence, slot_linked,
//                                                      occupied_count, status
//   config    cfg_we / cfg_wdata                       requested_flows
//
// In the back end a put reads and checks P slots, P the number of slots
// probed (one slot memory read per cycle, at most the table size). Other ops
// do one slot read and then one execute step.
// After reset and after every config write a clearing pass writes one slot a
// cycle over the whole memory (the largest power of two not above
// TABLE_DEPTH slots); no input beat is taken meanwhile.
// A two-entry command queue keeps input beats flowing while a result waits.
// ============================================================================
module flow_slot_allocator_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [10:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          op,
    input  logic [31:0]         flow_id,
    input  logic [9:0]          slot_index,
    input  logic signed [63:0]  write_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         new_id,
    output logic [31:0]         slot_flow_id,
    output logic signed [63:0]  slot_sequence,
    output logic [31:0]         slot_linked,
    output logic [10:0]         occupied_count,
    output logic [1:0]          status
);
    import fsa_pkg::*;

    localparam int CAP    = (2 ** $clog2(TABLE_DEPTH) == TABLE_DEPTH) ?
                            TABLE_DEPTH : 2 ** ($clog2(TABLE_DEPTH) - 1);
    localparam int ADDR_W = $clog2(CAP);

    cmd_t              push_cmd;
    cmd_t              head;
    logic              push;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              clearing;
    logic              cfg_clear;
    logic [ADDR_W-1:0] mask;

    // Accept and classify
    fsa_front #(
        .ADDR_W (ADDR_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .flow_id     (flow_id),
        .slot_index  (slot_index),
        .write_value (write_value),
        .q_full      (q_full),
        .clearing    (clearing),
        .push        (push),
        .cmd         (push_cmd),
        .mask        (mask),
        .cfg_clear   (cfg_clear)
    );

    // Decouple front and back
    fsa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty)
    );

    // Execute against the slot memory
    fsa_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_clear      (cfg_clear),
        .mask           (mask),
        .head           (head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_id         (new_id),
        .slot_flow_id   (slot_flow_id),
        .slot_sequence  (slot_sequence),
        .slot_linked    (slot_linked),
        .occupied_count (occupied_count),
        .status         (status)
    );

endmodule

// File: sim/tb.sv
// ============================================================================
// tb
// Self-checking bench for flow_slot_allocator_top. A local flow table model
// predicts every result beat from the accepted input beats and the current
// table size; a checker compares each result beat field by field with the
// oldest prediction. Directed cases cover one-slot and four-slot tables,
// full tables, clear mismatches, unchecked access and unused op codes;
// random phases run mostly well-formed traffic on live ids at several sizes.
// ============================================================================
module tb;
    import fsa_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned LIMIT_CYCLES = 3_000_000;

    // Op codes the block leaves unused
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [31:0] new_id;
        logic [31:0] slot_id;
        logic [63:0] slot_seq;
        logic [31:0] slot_link;
        logic [10:0] occupied;
        logic [1:0]  status;
    } flow_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [10:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         op;
    logic [31:0]        flow_id;
    logic [9:0]         slot_index;
    logic signed [63:0] write_value;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        new_id;
    logic [31:0]        slot_flow_id;
    logic signed [63:0] slot_sequence;
    logic [31:0]        slot_linked;
    logic [10:0]        occupied_count;
    logic [1:0]         status;

    // Flow table model
    logic [31:0]  flow_ids   [TABLE_DEPTH];
    logic [63:0]  flow_seqs  [TABLE_DEPTH];
    logic [31:0]  flow_links [TABLE_DEPTH];
    logic [31:0]  id_counter;
    int unsigned  live_count;
    int unsigned  table_slots;

    flow_result_t awaited_results[$];
    int unsigned  mismatch_count;
    bit           send_gaps;
    bit           recv_stalls;

    flow_slot_allocator_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .flow_id(flow_id),
        .slot_index(slot_index),
        .write_value(write_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .new_id(new_id),
        .slot_flow_id(slot_flow_id),
        .slot_sequence(slot_sequence),
        .slot_linked(slot_linked),
        .occupied_count(occupied_count),
        .status(status)
    );

    // Free-running clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Empty every slot and size the table from the request
    function automatic void rebuild_table(input logic [10:0] req);
        int unsigned cap;
        int unsigned i;
        cap = 1;
        while (cap * 2 <= TABLE_DEPTH)
            cap = cap * 2;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            flow_ids[IDX_W'(i)]   = '0;
            flow_seqs[IDX_W'(i)]  = '1;
            flow_links[IDX_W'(i)] = '0;
        end
        id_counter  = '0;
        live_count  = 0;
        table_slots = 1;
        while (table_slots < req && table_slots < cap)
            table_slots = table_slots * 2;
    endfunction

    // Advance the id counter, skipping zero on wrap
    function automatic logic [31:0] bump_id(input logic [31:0] c);
        logic [31:0] n;
        n = c + 32'd1;
        return (n == 32'd0) ? 32'd1 : n;
    endfunction

    // Apply one op to the model and return the result it produces
    function automatic flow_result_t predict_flow_op(input logic [2:0] code,
                                                     input logic [31:0] fid,
                                                     input logic [9:0] sidx,
                                                     input logic [63:0] wval);
        flow_result_t     r;
        logic [31:0]      mask;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] s;
        int unsigned      k;
        bit               found;
        bit               show;
        mask     = table_slots - 1;
        slot     = IDX_W'(fid & mask);
        r.new_id = '0;
        r.status = STATUS_OK;
        show     = 1'b1;
        case (code)
            OP_PUT:
            begin
                found = 1'b0;
                id_counter = bump_id(id_counter);
                for (k = 0; k < table_slots && !found; k++)
                begin
                    s = IDX_W'(id_counter & mask);
                    if (flow_ids[s] == 32'd0)
                    begin
                        flow_ids[s]   = id_counter;
                        flow_seqs[s]  = '1;
                        flow_links[s] = '0;
                        r.new_id      = id_counter;
                        slot          = s;
                        found         = 1'b1;
                        live_count++;
                    end
                    id_counter = bump_id(id_counter);
                end
                if (!found)
                begin
                    r.status = STATUS_FULL;
                    show     = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                if (fid != 32'd0 && flow_ids[slot] == fid)
                begin
                    flow_ids[slot]   = '0;
                    flow_seqs[slot]  = '1;
                    flow_links[slot] = '0;
                    if (live_count > 0)
                        live_count--;
                end
                else
                    r.status = STATUS_MISMATCH;
            end
            OP_READ:
                ;
            OP_SET_SEQ:
                flow_seqs[slot] = wval;
            OP_SET_LINK:
                flow_links[slot] = wval[31:0];
            OP_AT_INDEX:
                slot = IDX_W'(sidx & mask);
            default:
                show = 1'b0;
        endcase
        r.slot_id   = show ? flow_ids[slot]   : '0;
        r.slot_seq  = show ? flow_seqs[slot]  : '0;
        r.slot_link = show ? flow_links[slot] : '0;
        r.occupied  = 11'(live_count);
        return r;
    endfunction

    // Pick the id of an occupied slot, or a random id if none turns up
    function automatic logic [31:0] live_flow_id();
        int unsigned t;
        int unsigned s;
        for (t = 0; t < 8; t++)
        begin
            s = $urandom_range(0, table_slots - 1);
            if (flow_ids[IDX_W'(s)] != 32'd0)
                return flow_ids[IDX_W'(s)];
        end
        return $urandom;
    endfunction

    // Drive one input beat and record its prediction once it is taken
    task automatic send_flow_op(input logic [2:0] code, input logic [31:0] fid,
                                input logic [9:0] sidx, input logic [63:0] wval);
        flow_result_t predicted;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= code;
        flow_id     <= fid;
        slot_index  <= sidx;
        write_value <= wval;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_flow_op(code, fid, sidx, wval);
        awaited_results.insert(awaited_results.size(), predicted);
    endtask

    // Drop valid and hold until every predicted beat has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Rewrite the requested size once the block is idle
    task automatic write_requested_flows(input logic [10:0] req);
        wait_results_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= req;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rebuild_table(req);
    endtask

    // One-slot table: fill, full, clear cases, unchecked access, spare ops
    task automatic test_single_slot();
        logic [31:0] live;
        write_requested_flows(11'd0);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        send_flow_op(OP_PUT, 32'd0, 10'd0, 64'd0);
        send_flow_op(OP_PUT, 32'd0, 10'd0, 64'd0);
        live = flow_ids[0];
        send_flow_op(OP_READ, live, 10'd0, 64'd0);
        send_flow_op(OP_SET_SEQ, live, 10'd0, 64'h8000_0000_0000_0000);
        send_flow_op(OP_SET_LINK, live, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_flow_op(OP_READ, live ^ 32'h8000_0000, 10'd0, 64'd0);
        send_flow_op(OP_CLEAR, live ^ 32'h8000_0000, 10'd0, 64'd0);
        send_flow_op(OP_CLEAR, live, 10'd0, 64'd0);
        send_flow_op(OP_CLEAR, live, 10'd0, 64'd0);
        send_flow_op(OP_CLEAR, 32'd0, 10'd0, 64'd0);
        send_flow_op(OP_SET_SEQ, 32'hFFFF_FFFF, 10'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_flow_op(OP_AT_INDEX, 32'd0, 10'h3FF, 64'd0);
        send_flow_op(OP_SPARE_LO, 32'hFFFF_FFFF, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_flow_op(OP_SPARE_HI, 32'd0, 10'd0, 64'd0);
        // a put into the emptied slot resets the sequence written above
        send_flow_op(OP_PUT, 32'd0, 10'd0, 64'd0);
    endtask

    // Four-slot table: fill it, hit the probe bound, index extremes
    task automatic test_full_small_table();
        int unsigned n;
        write_requested_flows(11'd3);
        for (n = 0; n < 5; n++)
            send_flow_op(OP_PUT, 32'd0, 10'd0, 64'd0);
        send_flow_op(OP_READ, 32'hFFFF_FFFF, 10'd0, 64'd0);
        send_flow_op(OP_AT_INDEX, 32'd0, 10'h3FF, 64'd0);
        send_flow_op(OP_AT_INDEX, 32'd0, 10'd0, 64'd0);
        send_flow_op(OP_CLEAR, flow_ids[2], 10'd0, 64'd0);
        send_flow_op(OP_PUT, 32'd0, 10'd0, 64'd0);
        // counter wrap needs 2^32 allocations and is out of reach here
    endtask

    // Mostly well-formed traffic on live ids, with some noise
    task automatic test_random_traffic(input logic [10:0] req, input int unsigned beats,
                                       input bit idling);
        int unsigned n;
        int unsigned pick;
        logic [31:0] fid;
        logic [2:0]  code;
        write_requested_flows(req);
        send_gaps   = idling;
        recv_stalls = idling;
        for (n = 0; n < beats; n++)
        begin
            if (idling && n % 32 == 0)
            begin
                send_gaps   = $urandom_range(0, 2) != 0;
                recv_stalls = $urandom_range(0, 2) != 0;
            end
            if (n > 0 && $urandom_range(0, 63) == 0)
                wait_results_drained();
            pick = $urandom_range(0, 99);
            fid  = live_flow_id();
            if (pick < 30)
                code = OP_PUT;
            else if (pick < 48)
                code = OP_CLEAR;
            else if (pick < 53)
            begin
                // same slot, different id
                code = OP_CLEAR;
                fid  = fid + table_slots * $urandom_range(1, 3);
            end
            else if (pick < 63)
                code = OP_READ;
            else if (pick < 73)
                code = OP_SET_SEQ;
            else if (pick < 81)
                code = OP_SET_LINK;
            else if (pick < 91)
                code = OP_AT_INDEX;
            else if (pick < 96)
            begin
                code = ($urandom_range(0, 1) != 0) ? OP_SET_LINK : OP_READ;
                fid  = $urandom;
            end
            else
                code = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
            send_flow_op(code, fid, 10'($urandom_range(0, 1023)), {$urandom, $urandom});
        end
    endtask

    // Compare one field and log a mismatch
    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver stalls in random bursts
    always
    begin
        @(posedge clk);
        if (recv_stalls && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            out_ready <= 1'b1;
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin : result_check
        flow_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result beat with nothing predicted, new_id %h status %h",
                         $time, new_id, status);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                report_field("new_id", 64'(want.new_id), 64'(new_id));
                report_field("slot_flow_id", 64'(want.slot_id), 64'(slot_flow_id));
                report_field("slot_sequence", want.slot_seq, slot_sequence);
                report_field("slot_linked", 64'(want.slot_link), 64'(slot_linked));
                report_field("occupied_count", 64'(want.occupied), 64'(occupied_count));
                report_field("status", 64'(want.status), 64'(status));
            end
        end
    end

    // Hard stop on a hang
    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("FAIL flow_slot_allocator_top");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        op             = OP_PUT;
        flow_id        = '0;
        slot_index     = '0;
        write_value    = '0;
        out_ready      = 1'b1;
        send_gaps      = 1'b0;
        recv_stalls    = 1'b0;
        mismatch_count = 0;
        rebuild_table(11'd1024);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_single_slot();
        test_full_small_table();
        test_random_traffic(11'd5, 90, 1'b1);
        test_random_traffic(11'd2047, 90, 1'b1);
        test_random_traffic(11'd1, 60, 1'b1);
        test_random_traffic(11'd16, 90, 1'b1);
        test_random_traffic(11'd1023, 90, 1'b1);
        test_random_traffic(11'd2, 60, 1'b1);
        // closing phase runs at full rate on both sides
        test_random_traffic(11'd100, 100, 1'b0);

        wait_results_drained();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS flow_slot_allocator_top");
        else
            $display("FAIL flow_slot_allocator_top");
        $finish;
    end

endmodule
